// File: hdl/sfr_pkg.sv
// Shared types, codes, constants and the FCS-16 byte update of the serial frame receiver.
`default_nettype none

package sfr_pkg;

  // Width of the elapsed-time counters; the timeouts themselves are 32 bits.
  localparam int unsigned TIMER_BITS = 32;
  localparam int unsigned TIMEOUT_W  = 32;
  localparam int unsigned CMP_W      = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

  // Configuration port.
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECEIVE_MODE    = 3'd0,
    CFG_EXPECTED_ACK_ID = 3'd1,
    CFG_SYMBOL_TIMEOUT  = 3'd2,
    CFG_RESET_TIMEOUT   = 3'd3,
    CFG_RESEND_TIMEOUT  = 3'd4
  } sfr_cfg_idx_e;

  localparam logic [TIMEOUT_W-1:0] SYMBOL_TIMEOUT_RST = 32'd10000;

  // Request function codes.
  typedef enum logic [2:0] {
    FUNC_BYTE         = 3'd0,
    FUNC_TICK         = 3'd1,
    FUNC_RESET_START  = 3'd2,
    FUNC_RESEND_START = 3'd3,
    FUNC_RESET_STOP   = 3'd4,
    FUNC_RESEND_STOP  = 3'd5
  } sfr_func_e;

  // Result kinds.
  typedef enum logic [2:0] {
    EV_PASS    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_OK      = 3'd2,
    EV_DROP    = 3'd3,
    EV_ACKOK   = 3'd4,
    EV_RESET   = 3'd5,
    EV_RESEND  = 3'd6
  } sfr_event_e;

  // Receiver phases, one-hot.
  typedef enum logic [7:0] {
    PH_HUNT   = 8'b0000_0001,
    PH_HDR    = 8'b0000_0010,
    PH_STX    = 8'b0000_0100,
    PH_BODY   = 8'b0000_1000,
    PH_ETX    = 8'b0001_0000,
    PH_EOT    = 8'b0010_0000,
    PH_ACKB   = 8'b0100_0000,
    PH_ACKEOT = 8'b1000_0000
  } sfr_phase_e;

  // Control characters.
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;

  // PPP FCS-16.
  localparam logic [15:0] FCS_START = 16'hffff;
  localparam logic [15:0] FCS_GOOD  = 16'hf0b8;
  localparam logic [15:0] FCS_POLY  = 16'h8408;

  // Frame byte counts.
  localparam int unsigned CNT_W   = 17;
  localparam logic [CNT_W-1:0] HDR_BYTES = 17'd10;
  localparam logic [CNT_W-1:0] ACK_BYTES = 17'd4;
  localparam logic [CNT_W-1:0] FCS_BYTES = 17'd2;

  typedef struct packed {
    logic                 receive_mode;
    logic [15:0]          expected_ack_id;
    logic [TIMEOUT_W-1:0] symbol_timeout;
    logic [TIMEOUT_W-1:0] reset_timeout;
    logic [TIMEOUT_W-1:0] resend_timeout;
  } sfr_cfg_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] rx_byte;
  } sfr_item_t;

  typedef struct packed {
    logic       valid;
    sfr_event_e kind;
    logic [7:0] data_byte;
    logic [15:0] frame_id;
    logic [15:0] payload_length;
    logic [31:0] frame_type;
  } sfr_result_t;

  // One byte through the reflected FCS-16 register, a bit per step.
  function automatic logic [15:0] fcs_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sfr_core.sv
// Frame parser, FCS checker and timeout timers of the serial frame receiver.
`default_nettype none

module sfr_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire sfr_pkg::sfr_item_t  item_i,
  input  wire sfr_pkg::sfr_cfg_t   cfg_i,
  output sfr_pkg::sfr_result_t     res_o
);
  import sfr_pkg::*;

  sfr_phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [15:0]            crc_q, crc_d;
  logic [15:0]            hid_q, hid_d;
  logic [15:0]            hlen_q, hlen_d;
  logic [31:0]            htype_q, htype_d;
  logic [TIMER_BITS-1:0]  sym_q, sym_d;
  logic [TIMER_BITS-1:0]  rst_q, rst_d;
  logic [TIMER_BITS-1:0]  rsd_q, rsd_d;
  logic                   rst_on_q, rst_on_d;
  logic                   rsd_on_q, rsd_on_d;

  // Per-request helpers.
  logic [7:0]             b;
  logic [15:0]            crc_upd;
  logic [CNT_W-1:0]       cnt_inc;
  logic [CNT_W-1:0]       len_p2;
  logic [TIMER_BITS-1:0]  sym_inc, rst_inc, rsd_inc;
  logic                   sym_exp, rst_exp, rsd_exp;

  assign b       = item_i.rx_byte;
  assign crc_upd = fcs_step(crc_q, b);
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign len_p2  = CNT_W'(hlen_q) + FCS_BYTES;

  // Saturating tick counts and their expiry compares.
  assign sym_inc = (sym_q == '1) ? sym_q : sym_q + TIMER_BITS'(1);
  assign rst_inc = (rst_q == '1) ? rst_q : rst_q + TIMER_BITS'(1);
  assign rsd_inc = (rsd_q == '1) ? rsd_q : rsd_q + TIMER_BITS'(1);
  assign sym_exp = CMP_W'(sym_inc) >= CMP_W'(cfg_i.symbol_timeout);
  assign rst_exp = CMP_W'(rst_inc) >= CMP_W'(cfg_i.reset_timeout);
  assign rsd_exp = CMP_W'(rsd_inc) >= CMP_W'(cfg_i.resend_timeout);

  // Next state and result for the request at hand.
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    hid_d    = hid_q;
    hlen_d   = hlen_q;
    htype_d  = htype_q;
    sym_d    = sym_q;
    rst_d    = rst_q;
    rsd_d    = rsd_q;
    rst_on_d = rst_on_q;
    rsd_on_d = rsd_on_q;
    res_o    = '0;
    res_o.kind = EV_PASS;

    case (sfr_func_e'(item_i.func))
      FUNC_BYTE: begin
        if (phase_q != PH_HUNT) begin
          sym_d = '0;
        end
        case (phase_q)
          PH_HDR: begin
            crc_d = crc_upd;
            case (cnt_q[3:0])
              4'd0:    hid_d = {8'h00, b};
              4'd1:    hid_d = {b, hid_q[7:0]};
              4'd2:    hlen_d = {8'h00, b};
              4'd3:    hlen_d = {b, hlen_q[7:0]};
              4'd4:    htype_d = {24'h0, b};
              4'd5:    htype_d[15:8] = b;
              4'd6:    htype_d[23:16] = b;
              4'd7:    htype_d[31:24] = b;
              default: ;
            endcase
            cnt_d = cnt_inc;
            if (cnt_inc >= HDR_BYTES) begin
              if (crc_upd != FCS_GOOD) begin
                phase_d     = PH_HUNT;
                res_o.valid = 1'b1;
                res_o.kind  = EV_DROP;
              end else begin
                phase_d = PH_STX;
              end
            end
          end
          PH_STX: begin
            if (b != CH_STX) begin
              phase_d     = PH_HUNT;
              res_o.valid = 1'b1;
              res_o.kind  = EV_DROP;
            end else begin
              phase_d = PH_BODY;
              cnt_d   = '0;
              crc_d   = FCS_START;
            end
          end
          PH_BODY: begin
            crc_d = crc_upd;
            cnt_d = cnt_inc;
            if (cnt_inc >= len_p2) begin
              phase_d = PH_ETX;
            end
            // Payload streams out before the body FCS is known.
            if (cnt_inc <= CNT_W'(hlen_q)) begin
              res_o.valid     = 1'b1;
              res_o.kind      = EV_PAYLOAD;
              res_o.data_byte = b;
            end
          end
          PH_ETX: begin
            if (b != CH_ETX) begin
              phase_d     = PH_HUNT;
              res_o.valid = 1'b1;
              res_o.kind  = EV_DROP;
            end else begin
              phase_d = PH_EOT;
            end
          end
          PH_EOT: begin
            phase_d     = PH_HUNT;
            res_o.valid = 1'b1;
            if (b != CH_EOT || crc_q != FCS_GOOD) begin
              res_o.kind = EV_DROP;
            end else begin
              res_o.kind           = EV_OK;
              res_o.frame_id       = hid_q;
              res_o.payload_length = hlen_q;
              res_o.frame_type     = htype_q;
            end
          end
          PH_ACKB: begin
            crc_d = crc_upd;
            if (cnt_q == '0) begin
              hid_d = {8'h00, b};
            end else if (cnt_q == CNT_W'(1)) begin
              hid_d = {b, hid_q[7:0]};
            end
            cnt_d = cnt_inc;
            if (cnt_inc >= ACK_BYTES) begin
              phase_d = PH_ACKEOT;
            end
          end
          PH_ACKEOT: begin
            phase_d     = PH_HUNT;
            res_o.valid = 1'b1;
            if (b != CH_EOT || crc_q != FCS_GOOD || hid_q != cfg_i.expected_ack_id) begin
              res_o.kind = EV_DROP;
            end else begin
              res_o.kind     = EV_ACKOK;
              res_o.frame_id = hid_q;
            end
          end
          default: begin
            // Hunting: a start byte of the current mode opens a frame.
            phase_d = PH_HUNT;
            if (!cfg_i.receive_mode && b == CH_SOH) begin
              phase_d = PH_HDR;
              cnt_d   = '0;
              crc_d   = FCS_START;
              sym_d   = '0;
            end else if (cfg_i.receive_mode && b == CH_ACK) begin
              phase_d = PH_ACKB;
              cnt_d   = '0;
              crc_d   = FCS_START;
              sym_d   = '0;
            end else begin
              res_o.valid     = 1'b1;
              res_o.kind      = EV_PASS;
              res_o.data_byte = b;
            end
          end
        endcase
      end
      FUNC_TICK: begin
        sym_d = sym_inc;
        rst_d = rst_inc;
        rsd_d = rsd_inc;
        if (phase_q != PH_HUNT) begin
          if (sym_exp) begin
            phase_d     = PH_HUNT;
            res_o.valid = 1'b1;
            res_o.kind  = EV_DROP;
          end
        end else if (rst_on_q && rst_exp) begin
          // Reset timeout wins over resend timeout.
          rst_d       = '0;
          res_o.valid = 1'b1;
          res_o.kind  = EV_RESET;
        end else if (rsd_on_q && rsd_exp) begin
          rsd_d       = '0;
          res_o.valid = 1'b1;
          res_o.kind  = EV_RESEND;
        end
      end
      FUNC_RESET_START: begin
        rst_d    = '0;
        rst_on_d = 1'b1;
      end
      FUNC_RESEND_START: begin
        rsd_d    = '0;
        rsd_on_d = 1'b1;
      end
      FUNC_RESET_STOP: begin
        rst_on_d = 1'b0;
      end
      FUNC_RESEND_STOP: begin
        rsd_on_d = 1'b0;
      end
      default: ;
    endcase
  end

  // State registers advance once per request that moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      cnt_q    <= '0;
      crc_q    <= FCS_START;
      hid_q    <= '0;
      hlen_q   <= '0;
      htype_q  <= '0;
      sym_q    <= '0;
      rst_q    <= '0;
      rsd_q    <= '0;
      rst_on_q <= 1'b0;
      rsd_on_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      hid_q    <= hid_d;
      hlen_q   <= hlen_d;
      htype_q  <= htype_d;
      sym_q    <= sym_d;
      rst_q    <= rst_d;
      rsd_q    <= rsd_d;
      rst_on_q <= rst_on_d;
      rsd_on_q <= rsd_on_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/serial_frame_receiver_top.sv
// Top level of the serial frame receiver: ports, configuration, input and result registers.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       in_valid_i / in_stall_o    func_i, rx_byte_i
//   out      source     out_valid_o / out_stall_i  event_kind_o, data_byte_o, frame_id_o,
//                                                  payload_length_o, frame_type_o
//   cfg      sink       cfg_we_i                   cfg_index_i, cfg_data_i
//
// Requests are taken at one per cycle while in_stall_o is low; each sits in the input register
// while the parser works on it, and its result is then registered in the result register.
// The parser updates its state in the cycle a request leaves the input register.
// A stalled result holds the result register; the input register then fills and raises
// in_stall_o combinationally from out_stall_i.
// Reset clears the valid flags, the frame state and the timers at once and loads the configuration defaults.
`default_nettype none

module serial_frame_receiver_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Request channel.
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [2:0]                   func_i,
  input  wire logic [7:0]                   rx_byte_i,
  // Result channel.
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [2:0]                        event_kind_o,
  output logic [7:0]                        data_byte_o,
  output logic [15:0]                       frame_id_o,
  output logic [15:0]                       payload_length_o,
  output logic [31:0]                       frame_type_o,
  // Configuration write port.
  input  wire logic                         cfg_we_i,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [sfr_pkg::CFG_W-1:0]    cfg_data_i
);
  import sfr_pkg::*;

  sfr_cfg_t    cfg_q;
  logic        in_vld_q;
  sfr_item_t   item_q;
  logic        out_vld_q;
  sfr_result_t res_q;
  sfr_result_t res;
  logic        advance;
  logic        step;
  logic        in_take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.receive_mode    <= 1'b0;
      cfg_q.expected_ack_id <= '0;
      cfg_q.symbol_timeout  <= SYMBOL_TIMEOUT_RST;
      cfg_q.reset_timeout   <= '0;
      cfg_q.resend_timeout  <= '0;
    end else if (cfg_we_i) begin
      case (sfr_cfg_idx_e'(cfg_index_i))
        CFG_RECEIVE_MODE:    cfg_q.receive_mode    <= cfg_data_i[0];
        CFG_EXPECTED_ACK_ID: cfg_q.expected_ack_id <= cfg_data_i[15:0];
        CFG_SYMBOL_TIMEOUT:  cfg_q.symbol_timeout  <= cfg_data_i[TIMEOUT_W-1:0];
        CFG_RESET_TIMEOUT:   cfg_q.reset_timeout   <= cfg_data_i[TIMEOUT_W-1:0];
        CFG_RESEND_TIMEOUT:  cfg_q.resend_timeout  <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: the input register moves on whenever the result register is free.
  assign advance    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.func    <= func_i;
      item_q.rx_byte <= rx_byte_i;
    end
  end

  sfr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign event_kind_o     = 3'(res_q.kind);
  assign data_byte_o      = res_q.data_byte;
  assign frame_id_o       = res_q.frame_id;
  assign payload_length_o = res_q.payload_length;
  assign frame_type_o     = res_q.frame_type;

`ifndef NO_ASSERTIONS
  // An empty result register never holds back requests.
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> !in_stall_o)
    else $error("request stalled while the result register is empty");

  // A new result only comes from a request that sat in the input register.
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("result appeared without a request behind it");

  // Status results carry no byte.
  a_status_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.kind != EV_PASS && res_q.kind != EV_PAYLOAD |-> res_q.data_byte == 8'h00)
    else $error("status result carries a data byte");
`endif

endmodule

`default_nettype wire
